>>> src/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, op codes and controller/datapath command structs for the
// 4x4 homogeneous matrix transform engine.
// ----------------------------------------------------------------------------
package mte_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    // op codes
    localparam logic [2:0] OP_WR_CUR    = 3'd0;
    localparam logic [2:0] OP_WR_STG    = 3'd1;
    localparam logic [2:0] OP_COMPOSE   = 3'd2;
    localparam logic [2:0] OP_TRANSPOSE = 3'd3;
    localparam logic [2:0] OP_XFORM     = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    // result kinds
    localparam logic KIND_VEC  = 1'b0;
    localparam logic KIND_ELEM = 1'b1;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef struct packed {
        logic       latch;
        logic       wr_cur;
        logic       wr_stg;
        logic       transpose;
        logic       read_elem;
        logic       issue;
        logic       issue_compose;
        logic       issue_last;
        logic [1:0] issue_row;
        logic [1:0] issue_col;
        logic       out_load;
        logic       out_kind;
    } mte_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } mte_status_t;

endpackage

>>> src/matrix_transform_engine.sv
// ----------------------------------------------------------------------------
// matrix_transform_engine
// transform: issue four row dot products, drain, load output; read: load
// element, then output; a new transaction is accepted only once the last is
// done; dot products use the shared four-multiplier unit, one row dot
// product per cycle, and its three-stage pipeline; reset: sync active-low
// aresetn: current matrix to identity, control cleared, staged matrix undefined
// ----------------------------------------------------------------------------
module matrix_transform_engine
    import mte_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input transaction channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [1:0] s_row,
    input  logic [1:0] s_col,
    input  q_t         s_value,
    input  q_t         s_vec_x,
    input  q_t         s_vec_y,
    input  q_t         s_vec_z,
    input  q_t         s_vec_w,
    // result transaction channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output q_t         m_res_x,
    output q_t         m_res_y,
    output q_t         m_res_z,
    output q_t         m_res_w
);

    mte_cmd_t    cmd;
    mte_status_t status;
    q_t          res_x, res_y, res_z, res_w;
    logic        out_free;

    // output register: a finished result parks here so the engine can
    // accept the next transaction while the consumer stalls
    logic m_valid_reg, m_valid_next;
    logic m_kind_reg, m_kind_next;
    q_t   m_res_x_reg, m_res_x_next;
    q_t   m_res_y_reg, m_res_y_next;
    q_t   m_res_z_reg, m_res_z_next;
    q_t   m_res_w_reg, m_res_w_next;

    // sequencer: decode, element ops, dot-product issue, drain, hand-off
    mte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    // matrices and the multiply / add / saturate pipeline
    mte_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_row   (s_row),
        .s_col   (s_col),
        .s_value (s_value),
        .s_vec_x (s_vec_x),
        .s_vec_y (s_vec_y),
        .s_vec_z (s_vec_z),
        .s_vec_w (s_vec_w),
        .res_x   (res_x),
        .res_y   (res_y),
        .res_z   (res_z),
        .res_w   (res_w)
    );

    // slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);
        m_kind_next  = m_kind_reg;
        m_res_x_next = m_res_x_reg;
        m_res_y_next = m_res_y_reg;
        m_res_z_next = m_res_z_reg;
        m_res_w_next = m_res_w_reg;
        if (cmd.out_load) begin
            m_kind_next  = cmd.out_kind;
            m_res_x_next = res_x;
            m_res_y_next = res_y;
            m_res_z_next = res_z;
            m_res_w_next = res_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload holds no reset
    always_ff @(posedge aclk) begin
        m_kind_reg  <= m_kind_next;
        m_res_x_reg <= m_res_x_next;
        m_res_y_reg <= m_res_y_next;
        m_res_z_reg <= m_res_z_next;
        m_res_w_reg <= m_res_w_next;
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_res_x = m_res_x_reg;
    assign m_res_y = m_res_y_reg;
    assign m_res_z = m_res_z_reg;
    assign m_res_w = m_res_w_reg;

endmodule

>>> src/mte_ctrl.sv
// ----------------------------------------------------------------------------
// mte_ctrl
// Operation sequencer: decodes the accepted transaction and steps the
// datapath through element access, transpose or dot-product issue.
// ----------------------------------------------------------------------------
module mte_ctrl
    import mte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic        out_free,
    input  mte_status_t status,
    output mte_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_TRANSP = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_ISSUE  = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       compose;
    logic       issue_done;

    assign compose    = (op_reg == OP_COMPOSE);
    assign issue_done = compose ? (cnt_reg == 4'hf) : (cnt_reg[1:0] == 2'd3);
    assign s_ready    = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch = 1'b1;
                    op_next   = s_op;
                    cnt_next  = '0;
                    unique case (s_op) inside
                        OP_WR_CUR, OP_WR_STG: state_next = S_WRITE;
                        OP_COMPOSE, OP_XFORM: state_next = S_ISSUE;
                        OP_TRANSPOSE:         state_next = S_TRANSP;
                        OP_READ:              state_next = S_READ;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE: begin
                cmd.wr_cur = (op_reg == OP_WR_CUR);
                cmd.wr_stg = (op_reg == OP_WR_STG);
                state_next = S_IDLE;
            end
            S_TRANSP: begin
                cmd.transpose = 1'b1;
                state_next    = S_IDLE;
            end
            S_READ: begin
                cmd.read_elem = 1'b1;
                state_next    = S_OUT;
            end
            S_ISSUE: begin
                cmd.issue         = 1'b1;
                cmd.issue_compose = compose;
                // compose walks (row, col) of the product; transform walks rows
                cmd.issue_row     = compose ? cnt_reg[3:2] : cnt_reg[1:0];
                cmd.issue_col     = cnt_reg[1:0];
                cmd.issue_last    = compose && (cnt_reg[1:0] == 2'd3);
                cnt_next          = cnt_reg + 4'd1;
                if (issue_done) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = compose ? S_IDLE : S_OUT;
                end
            end
            S_OUT: begin
                cmd.out_kind = (op_reg == OP_READ) ? KIND_ELEM : KIND_VEC;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_WR_CUR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> src/mte_dp.sv
// ----------------------------------------------------------------------------
// mte_dp
// Matrix storage and the shared four-multiplier dot-product pipeline
// (multiply, pairwise add, final add and saturate).
// ----------------------------------------------------------------------------
module mte_dp
    import mte_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  mte_cmd_t    cmd,
    output mte_status_t status,
    input  logic [1:0]  s_row,
    input  logic [1:0]  s_col,
    input  q_t          s_value,
    input  q_t          s_vec_x,
    input  q_t          s_vec_y,
    input  q_t          s_vec_z,
    input  q_t          s_vec_w,
    output q_t          res_x,
    output q_t          res_y,
    output q_t          res_z,
    output q_t          res_w
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int PAIR_W = SH_W + 1;
    localparam int SUM_W  = SH_W + 2;

    localparam logic [DATA_W-1:0] QONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};

    // latched transaction fields
    logic [1:0] row_l_reg, row_l_next;
    logic [1:0] col_l_reg, col_l_next;
    q_t         val_l_reg, val_l_next;
    q_t         vec_reg [4];
    q_t         vec_next[4];

    // current matrix [row][col], staged matrix kept by column [col][row]
    q_t cur_reg [4][4];
    q_t cur_next[4][4];
    q_t stg_reg [4][4];
    q_t stg_next[4][4];
    q_t lane_reg [4];
    q_t lane_next[4];

    // pipeline
    q_t                       opa[4];
    q_t                       opb[4];
    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PROD_W-1:0] prod_next[4];
    logic signed [SH_W-1:0]   sh[4];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next[2];
    logic signed [SUM_W-1:0]  sum;
    q_t                       sat;

    logic       v1_reg, v1_next, v2_reg, v2_next;
    logic [1:0] lane1_reg, lane1_next, lane2_reg, lane2_next;
    logic [1:0] row1_reg, row1_next, row2_reg, row2_next;
    logic       last1_reg, last1_next, last2_reg, last2_next;

    // stage 1: operand select and multiply
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            opa[k]       = cur_reg[cmd.issue_row][k];
            opb[k]       = cmd.issue_compose ? stg_reg[cmd.issue_col][k] : vec_reg[k];
            prod_next[k] = PROD_W'(opa[k]) * PROD_W'(opb[k]);
        end
        v1_next    = cmd.issue;
        lane1_next = cmd.issue_col;
        row1_next  = cmd.issue_row;
        last1_next = cmd.issue_last;
        if (!cmd.issue_compose) begin
            lane1_next = cmd.issue_row;
        end
    end

    // stage 2: truncating shift and pairwise add
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sh[k] = SH_W'(prod_reg[k] >>> FRAC_BITS);
        end
        pair_next[0] = PAIR_W'(sh[0]) + PAIR_W'(sh[1]);
        pair_next[1] = PAIR_W'(sh[2]) + PAIR_W'(sh[3]);
        v2_next      = v1_reg;
        lane2_next   = lane1_reg;
        row2_next    = row1_reg;
        last2_next   = last1_reg;
    end

    // stage 3: final add and saturate
    always_comb begin
        sum = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        if (sum > SAT_HI) begin
            sat = SAT_HI[DATA_W-1:0];
        end else if (sum < SAT_LO) begin
            sat = SAT_LO[DATA_W-1:0];
        end else begin
            sat = sum[DATA_W-1:0];
        end
    end

    // storage updates
    always_comb begin
        row_l_next = row_l_reg;
        col_l_next = col_l_reg;
        val_l_next = val_l_reg;
        vec_next   = vec_reg;
        cur_next   = cur_reg;
        stg_next   = stg_reg;
        lane_next  = lane_reg;

        if (cmd.latch) begin
            row_l_next  = s_row;
            col_l_next  = s_col;
            val_l_next  = s_value;
            vec_next[0] = s_vec_x;
            vec_next[1] = s_vec_y;
            vec_next[2] = s_vec_z;
            vec_next[3] = s_vec_w;
        end

        if (cmd.transpose) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 4; k++) begin
                    cur_next[i][k] = cur_reg[k][i];
                end
            end
        end else if (cmd.wr_cur) begin
            cur_next[row_l_reg][col_l_reg] = val_l_reg;
        end else if (v2_reg && last2_reg) begin
            // whole product row done: its source row is no longer needed
            for (int k = 0; k < 3; k++) begin
                cur_next[row2_reg][k] = lane_reg[k];
            end
            cur_next[row2_reg][3] = sat;
        end

        if (cmd.wr_stg) begin
            stg_next[col_l_reg][row_l_reg] = val_l_reg;
        end

        if (cmd.read_elem) begin
            lane_next[0] = cur_reg[row_l_reg][col_l_reg];
            lane_next[1] = '0;
            lane_next[2] = '0;
            lane_next[3] = '0;
        end else if (v2_reg) begin
            lane_next[lane2_reg] = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 4; k++) begin
                    cur_reg[i][k] <= (i == k) ? QONE : '0;
                end
            end
        end else begin
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_l_reg <= row_l_next;
        col_l_reg <= col_l_next;
        val_l_reg <= val_l_next;
        vec_reg   <= vec_next;
        stg_reg   <= stg_next;
        lane_reg  <= lane_next;
        prod_reg  <= prod_next;
        pair_reg  <= pair_next;
        lane1_reg <= lane1_next;
        row1_reg  <= row1_next;
        last1_reg <= last1_next;
        lane2_reg <= lane2_next;
        row2_reg  <= row2_next;
        last2_reg <= last2_next;
    end

    assign status.pipe_busy = v1_reg | v2_reg;

    assign res_x = lane_reg[0];
    assign res_y = lane_reg[1];
    assign res_z = lane_reg[2];
    assign res_w = lane_reg[3];

`ifndef NO_ASSERTIONS
    a_pipe_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> v2_reg)
        else $error("multiply stage result lost before add stage");

    a_wb_last_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && last2_reg) |-> (lane2_reg == 2'd3))
        else $error("row write-back before last column");

    a_no_cur_write_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_cur || cmd.transpose || cmd.read_elem) |-> !(v1_reg || v2_reg))
        else $error("current matrix touched while dot products in flight");
`endif

endmodule

>>> sim/matrix_transform_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_transform_engine_tb
// Self-checking bench for the 4x4 Q16.16 transform engine: a short scripted
// sequence with hand-computed answers at reset and at the saturation limits,
// then random element writes, composes, transposes, transforms and reads,
// every result scored against a bit-accurate model of both matrices.
// ----------------------------------------------------------------------------
module matrix_transform_engine_tb;
    import mte_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 600;

    // op codes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef logic [DATA_W-1:0] word_t;

    localparam word_t Q_ONE = word_t'(1) << FRAC;
    localparam word_t Q_MAX = 32'h7fff_ffff;
    localparam word_t Q_MIN = 32'h8000_0000;

    // one input transaction; vec[0] is x, vec[3] is w
    typedef struct packed {
        logic [2:0]              op;
        logic [1:0]              row;
        logic [1:0]              col;
        word_t                   value;
        logic [3:0][DATA_W-1:0]  vec;
    } op_item_t;

    // one output transaction; res[0] is x (or the element read)
    typedef struct packed {
        logic                    kind;
        logic [3:0][DATA_W-1:0]  res;
    } result_t;

    // scripted row: answer typed in by hand when known is set
    typedef struct packed {
        op_item_t item;
        logic     known;
        result_t  want;
    } script_row_t;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  [2:0] s_op;
    logic  [1:0] s_row;
    logic  [1:0] s_col;
    q_t    s_value;
    q_t    s_vec_x;
    q_t    s_vec_y;
    q_t    s_vec_z;
    q_t    s_vec_w;
    logic  m_valid;
    logic  m_ready;
    logic  m_kind;
    q_t    m_res_x;
    q_t    m_res_y;
    q_t    m_res_z;
    q_t    m_res_w;

    // model of the engine's matrices, row-major, index = {row, col}
    word_t       cur_mat [16];
    word_t       stg_mat [16];
    logic [15:0] stg_written;

    result_t     owed_outputs [$];
    script_row_t script [$];

    int error_count = 0;
    int tx_gap      = 0;
    int sent_count  = 0;
    int cycle_count = 0;

    matrix_transform_engine #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_row   (s_row),
        .s_col   (s_col),
        .s_value (s_value),
        .s_vec_x (s_vec_x),
        .s_vec_y (s_vec_y),
        .s_vec_z (s_vec_z),
        .s_vec_w (s_vec_w),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_res_x (m_res_x),
        .m_res_y (m_res_y),
        .m_res_z (m_res_z),
        .m_res_w (m_res_w)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // fixed-point arithmetic of the engine
    // ------------------------------------------------------------------------

    // four-term Q dot product: each product is exact at 64 bits and shifted
    // down arithmetically (floor), the sum is exact, then clamped to 32 bits
    function automatic word_t fx_dot(logic [3:0][DATA_W-1:0] a,
                                     logic [3:0][DATA_W-1:0] b);
        logic signed [63:0] acc;
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        acc = '0;
        for (int k = 0; k < 4; k++) begin
            wa = $signed(a[k]);
            wb = $signed(b[k]);
            acc += (wa * wb) >>> FRAC;
        end
        if (acc > 64'sd2147483647)
            return Q_MAX;
        if (acc < -64'sd2147483648)
            return Q_MIN;
        return acc[DATA_W-1:0];
    endfunction

    // advance the matrix model by one accepted transaction and queue the
    // result it owes, if any; scripted rows with a hand answer queue that one
    task automatic track_op(input op_item_t it, input logic known, input result_t want);
        word_t                  nxt [16];
        logic [3:0][DATA_W-1:0] lhs;
        logic [3:0][DATA_W-1:0] rhs;
        result_t                r;
        r = '0;
        case (it.op)
            OP_WR_CUR: begin
                cur_mat[{it.row, it.col}] = it.value;
            end
            OP_WR_STG: begin
                stg_mat[{it.row, it.col}]     = it.value;
                stg_written[{it.row, it.col}] = 1'b1;
            end
            OP_COMPOSE: begin
                // current = current x staged
                for (int i = 0; i < 4; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        for (int k = 0; k < 4; k++) begin
                            lhs[k] = cur_mat[i*4 + k];
                            rhs[k] = stg_mat[k*4 + j];
                        end
                        nxt[i*4 + j] = fx_dot(lhs, rhs);
                    end
                end
                cur_mat = nxt;
            end
            OP_TRANSPOSE: begin
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                        nxt[i*4 + j] = cur_mat[j*4 + i];
                cur_mat = nxt;
            end
            OP_XFORM: begin
                // column vector: res = current * v, one row dot product each
                r.kind = KIND_VEC;
                for (int i = 0; i < 4; i++) begin
                    for (int k = 0; k < 4; k++)
                        lhs[k] = cur_mat[i*4 + k];
                    r.res[i] = fx_dot(lhs, it.vec);
                end
                owed_outputs.push_back(known ? want : r);
            end
            OP_READ: begin
                // y, z and w of an element read are always zero
                r.kind   = KIND_ELEM;
                r.res[0] = cur_mat[{it.row, it.col}];
                owed_outputs.push_back(known ? want : r);
            end
            default: begin
                // spare op codes leave everything alone
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic op_item_t mk_item(logic [2:0] op, logic [1:0] row, logic [1:0] col,
                                         word_t value, word_t x, word_t y, word_t z,
                                         word_t w);
        op_item_t it;
        it.op    = op;
        it.row   = row;
        it.col   = col;
        it.value = value;
        it.vec   = {w, z, y, x};
        return it;
    endfunction

    function automatic result_t mk_result(logic kind, word_t x, word_t y, word_t z,
                                          word_t w);
        result_t r;
        r.kind = kind;
        r.res  = {w, z, y, x};
        return r;
    endfunction

    // mostly small Q values (within +/-2.0) so that composed matrices stay
    // in range for a while, with the limits and full-width noise mixed in
    function automatic word_t draw_q();
        case ($urandom_range(0, 15))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic op_item_t draw_item();
        op_item_t it;
        int       pick;
        pick     = $urandom_range(0, 99);
        it.row   = 2'($urandom_range(0, 3));
        it.col   = 2'($urandom_range(0, 3));
        it.value = draw_q();
        it.vec   = {draw_q(), draw_q(), draw_q(), draw_q()};
        if (pick < 24)
            it.op = OP_WR_CUR;
        else if (pick < 40)
            it.op = OP_WR_STG;
        else if (pick < 43)
            // compose only once every staged entry holds a written value
            it.op = (&stg_written) ? OP_COMPOSE : OP_WR_STG;
        else if (pick < 48)
            it.op = OP_TRANSPOSE;
        else if (pick < 74)
            it.op = OP_XFORM;
        else if (pick < 97)
            it.op = OP_READ;
        else
            it.op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
        return it;
    endfunction

    // sender idle time; every 500 transactions a run of 120 goes back to back
    function automatic int draw_gap();
        if (sent_count % 500 < 120)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // offer one transaction and hold it until accepted; valid only drops when
    // an idle gap or a pause follows, so back-to-back items keep it high
    task automatic send_item(input op_item_t it, input logic known, input result_t want,
                             input logic pause_after);
        repeat (tx_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_op    <= it.op;
        s_row   <= it.row;
        s_col   <= it.col;
        s_value <= it.value;
        s_vec_x <= it.vec[0];
        s_vec_y <= it.vec[1];
        s_vec_z <= it.vec[2];
        s_vec_w <= it.vec[3];
        do @(posedge aclk); while (s_ready !== 1'b1);
        track_op(it, known, want);
        sent_count++;
        tx_gap = draw_gap();
        if (tx_gap > 0 || pause_after)
            s_valid <= 1'b0;
        // pause: wait until every owed result has come back
        if (pause_after)
            do @(posedge aclk); while (owed_outputs.size() != 0);
    endtask

    task automatic note_error(input string what, input word_t want, input word_t got);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // stimulus: scripted part, then random traffic
    // ------------------------------------------------------------------------
    initial begin : stimulus
        op_item_t it;
        result_t  none_r;
        int       real_items;
        logic     pause;

        none_r  = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op    <= OP_WR_CUR;
        s_row   <= '0;
        s_col   <= '0;
        s_value <= '0;
        s_vec_x <= '0;
        s_vec_y <= '0;
        s_vec_z <= '0;
        s_vec_w <= '0;

        // model state after reset: identity current, nothing staged
        for (int i = 0; i < 16; i++) begin
            cur_mat[i] = (i % 5 == 0) ? Q_ONE : '0;
            stg_mat[i] = '0;
        end
        stg_written = '0;

        // reset contents read back: one on the diagonal, zero elsewhere
        script.push_back({mk_item(OP_READ, 2'd0, 2'd0, '0, '0, '0, '0, '0), 1'b1,
                          mk_result(KIND_ELEM, Q_ONE, '0, '0, '0)});
        script.push_back({mk_item(OP_READ, 2'd0, 2'd1, '1, '1, '1, '1, '1), 1'b1,
                          mk_result(KIND_ELEM, '0, '0, '0, '0)});
        // identity passes the vector through untouched, limits included
        script.push_back({mk_item(OP_XFORM, 2'd3, 2'd3, '0, Q_MAX, Q_MIN, '0, '1), 1'b1,
                          mk_result(KIND_VEC, Q_MAX, Q_MIN, '0, '1)});
        // spare op codes with all-ones and limit values on the fields: no result, no state change
        script.push_back({mk_item(OP_SPARE_A, 2'd3, 2'd3, '1, '1, '1, '1, '1), 1'b0,
                          none_r});
        script.push_back({mk_item(OP_SPARE_B, 2'd2, 2'd1, Q_MIN, Q_MIN, Q_MAX, '1, '0),
                          1'b0, none_r});
        // row 0 = [max max 0 0]: x overflows high, the other rows pass through
        script.push_back({mk_item(OP_WR_CUR, 2'd0, 2'd0, Q_MAX, '0, '0, '0, '0), 1'b0,
                          none_r});
        script.push_back({mk_item(OP_WR_CUR, 2'd0, 2'd1, Q_MAX, '0, '0, '0, '0), 1'b0,
                          none_r});
        script.push_back({mk_item(OP_XFORM, 2'd0, 2'd0, '0, Q_MAX, Q_MAX, '1, Q_MIN), 1'b1,
                          mk_result(KIND_VEC, Q_MAX, Q_MAX, '1, Q_MIN)});
        // row 0 = [min max 0 0]: x overflows low
        script.push_back({mk_item(OP_WR_CUR, 2'd0, 2'd0, Q_MIN, '0, '0, '0, '0), 1'b0,
                          none_r});
        script.push_back({mk_item(OP_XFORM, 2'd0, 2'd0, '0, Q_MAX, '0, 32'd5,
                                  -32'sd7), 1'b1,
                          mk_result(KIND_VEC, Q_MIN, '0, 32'd5, -32'sd7)});
        // transpose moves the max from (0,1) to (1,0)
        script.push_back({mk_item(OP_TRANSPOSE, 2'd0, 2'd0, '0, '0, '0, '0, '0), 1'b0,
                          none_r});
        script.push_back({mk_item(OP_READ, 2'd1, 2'd0, '0, '0, '0, '0, '0), 1'b1,
                          mk_result(KIND_ELEM, Q_MAX, '0, '0, '0)});
        // fill the whole staged matrix (1.5 diagonal, small off-diagonal),
        // then compose and look at the outcome through the model
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                script.push_back({mk_item(OP_WR_STG, 2'(r), 2'(c),
                                          (r == c) ? 32'h0001_8000 :
                                          $urandom_range(0, 32'h0000_8000) - 32'h0000_4000,
                                          '0, '0, '0, '0), 1'b0, none_r});
        script.push_back({mk_item(OP_COMPOSE, 2'd0, 2'd0, '0, '0, '0, '0, '0), 1'b0,
                          none_r});
        script.push_back({mk_item(OP_XFORM, 2'd0, 2'd0, '0, Q_ONE, 32'h0002_0000,
                                  32'hffff_0000, Q_ONE), 1'b0, none_r});
        script.push_back({mk_item(OP_READ, 2'd2, 2'd2, '0, '0, '0, '0, '0), 1'b0, none_r});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[n])
            send_item(script[n].item, script[n].known, script[n].want, 1'b0);

        // random traffic; spare op codes ride along but are not counted.
        // halfway and at the very end the sender waits for the results
        real_items = 0;
        while (real_items < RANDOM_ITEMS) begin
            it    = draw_item();
            pause = 1'b0;
            if (it.op <= OP_READ) begin
                real_items++;
                pause = (real_items % (RANDOM_ITEMS / 2) == 0);
            end
            send_item(it, 1'b0, none_r, pause);
        end

        // let any late or extra result show up before scoring
        repeat (DRAIN_CYCLES) @(posedge aclk);
        error_count += owed_outputs.size();
        if (error_count == 0)
            $display("matrix_transform_engine_tb: clean");
        else
            $display("matrix_transform_engine_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random back-pressure with one long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int   hold;
        int   taken;
        logic held_long;

        hold      = 0;
        taken     = 0;
        held_long = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken++;
                if (!held_long && taken == 200) begin
                    // stall long enough for the engine to back up its input
                    hold      = LONG_HOLD;
                    held_long = 1'b1;
                end else if (taken % 300 < 80) begin
                    hold = 0;
                end else begin
                    hold = $urandom_range(0, 15);
                end
                if (hold > 0)
                    m_ready <= 1'b0;
            end else if (!m_ready) begin
                if (hold > 0)
                    hold--;
                if (hold == 0)
                    m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // scoreboard: each result transaction against the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        string   lbl;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_res_w, m_res_z, m_res_y, m_res_x};
            if (owed_outputs.size() == 0) begin
                note_error("unexpected result", '0, got.res[0]);
            end else begin
                want = owed_outputs.pop_front();
                if (got.kind !== want.kind)
                    note_error("kind", word_t'(want.kind), word_t'(got.kind));
                for (int i = 0; i < 4; i++) begin
                    if (got.res[i] !== want.res[i]) begin
                        case (i)
                            0:       lbl = "res_x";
                            1:       lbl = "res_y";
                            2:       lbl = "res_z";
                            default: lbl = "res_w";
                        endcase
                        note_error(lbl, want.res[i], got.res[i]);
                    end
                end
            end
        end
    end

    // hang guard
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("matrix_transform_engine_tb: errors");
        $finish;
    end

endmodule
